// ===== hw/rtl/rdb_pkg.sv =====
// rdb_pkg: shared types, command codes and size constants for the reversible deque buffer.
// Used by rdb_front, rdb_cmd_fifo, rdb_back and reversible_deque_buffer. No dependencies.
package rdb_pkg;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int CMD_BITS           = 3;
  localparam int DATA_BITS          = 32;
  localparam int COUNT_BITS         = 7;

  localparam int CMDQ_DEPTH = 2;
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_REVERSE = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_DELETE  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_EMIT    = 3'd4;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_REVERSE,
    OP_DELETE,
    OP_EMIT,
    OP_INVALID
  } op_t;

  typedef enum logic [1:0] {
    RK_DATA,
    RK_ERROR,
    RK_EMPTY
  } res_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [DATA_BITS-1:0]  value;
    logic [COUNT_BITS-1:0] expected_count;
  } item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] value_res;
    logic                 is_error;
    logic                 is_empty;
    logic                 last;
  } result_t;

  typedef struct packed {
    op_t                   op;
    logic [DATA_BITS-1:0]  value;
    logic [COUNT_BITS-1:0] expected_count;
  } dec_t;

endpackage

// ===== hw/rtl/reversible_deque_buffer.sv =====
// Reversible deque buffer: list buffer with a lazy reverse flag.
// Path: an emit's first element passes front reg, queue, run state, memory read
//   and result queue; an error result or empty marker: front reg, queue, issue reg, result queue.
// Throughput: one command per cycle while the back end is idle and the result queue has
//   room; an emit run holds the back end, one memory read per element. Synchronous active-high rst clears all
//   control state; element memory is not cleared (no clearing pass, ready after reset).
module reversible_deque_buffer #(
  parameter int DEPTH      = rdb_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = rdb_pkg::VALUE_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  rdb_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output rdb_pkg::result_t result
);

  // front to queue
  logic          fq_valid;
  logic          fq_ready;
  rdb_pkg::dec_t fq_data;

  // queue to back
  logic          qb_valid;
  logic          qb_ready;
  rdb_pkg::dec_t qb_data;

  // Register and decode each transfer; unknown codes turn into an invalid op here.
  rdb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .dec_valid  (fq_valid),
    .dec_ready  (fq_ready),
    .dec        (fq_data)
  );

  // Hold decoded commands while the back end streams an emit run.
  rdb_cmd_fifo u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Execute commands on list state; emit results go out through a small queue.
  rdb_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (qb_valid),
    .cmd_ready    (qb_ready),
    .cmd          (qb_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== hw/rtl/rdb_front.sv =====
// rdb_front: input stage; registers each item and decodes its command code.
// Depends on rdb_pkg.
module rdb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  rdb_pkg::item_t  item,
  output logic            dec_valid,
  input  logic            dec_ready,
  output rdb_pkg::dec_t   dec
);

  logic          f_valid;
  rdb_pkg::dec_t f_dec;
  rdb_pkg::op_t  op_next;

  // map raw codes onto operations; unused codes become invalid
  always_comb begin
    case (item.command)
      rdb_pkg::CMD_CLEAR:   op_next = rdb_pkg::OP_CLEAR;
      rdb_pkg::CMD_APPEND:  op_next = rdb_pkg::OP_APPEND;
      rdb_pkg::CMD_REVERSE: op_next = rdb_pkg::OP_REVERSE;
      rdb_pkg::CMD_DELETE:  op_next = rdb_pkg::OP_DELETE;
      rdb_pkg::CMD_EMIT:    op_next = rdb_pkg::OP_EMIT;
      default:              op_next = rdb_pkg::OP_INVALID;
    endcase
  end

  assign item_ready = !f_valid || dec_ready;
  assign dec_valid  = f_valid;
  assign dec        = f_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (item_ready) begin
      f_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      f_dec.op             <= op_next;
      f_dec.value          <= item.value;
      f_dec.expected_count <= item.expected_count;
    end
  end

endmodule

// ===== hw/rtl/rdb_cmd_fifo.sv =====
// rdb_cmd_fifo: short queue of decoded commands between front and back.
// Depends on rdb_pkg.
module rdb_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  rdb_pkg::dec_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rdb_pkg::dec_t pop_data
);

  localparam int PW = (rdb_pkg::CMDQ_DEPTH > 1) ? $clog2(rdb_pkg::CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(rdb_pkg::CMDQ_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(rdb_pkg::CMDQ_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(rdb_pkg::CMDQ_DEPTH);

  rdb_pkg::dec_t     entries [rdb_pkg::CMDQ_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/rdb_back.sv =====
// rdb_back: executes decoded commands on the list state and element memory,
// streams emit runs through a registered read into a small result queue. Depends on rdb_pkg.
module rdb_back #(
  parameter int DEPTH      = rdb_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = rdb_pkg::VALUE_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  rdb_pkg::dec_t    cmd,
  output logic             result_valid,
  input  logic             result_ready,
  output rdb_pkg::result_t result
);

  localparam int IDX_W = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);
  localparam int OQ_PW = $clog2(rdb_pkg::OQ_DEPTH);
  localparam logic [rdb_pkg::OQ_CNT_W-1:0] OQ_FULL   = rdb_pkg::OQ_CNT_W'(rdb_pkg::OQ_DEPTH);
  localparam logic [rdb_pkg::OQ_CNT_W-1:0] OQ_CREDIT = rdb_pkg::OQ_CNT_W'(rdb_pkg::OQ_DEPTH - 2);

  // list state
  logic [IDX_W-1:0]               head;
  logic [IDX_W-1:0]               tail;
  logic [rdb_pkg::COUNT_BITS-1:0] loaded;
  logic [rdb_pkg::COUNT_BITS-1:0] declared;
  logic                           reversed;
  logic                           failed;

  // emit sequencer
  rdb_pkg::back_state_t state;
  rdb_pkg::back_state_t state_next;
  logic [IDX_W-1:0]     rd_ptr;
  logic [IDX_W-1:0]     rd_end;
  logic                 rd_down;

  // element memory
  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] mem_q;

  // issue stage (registered alongside the memory read)
  logic                 iss_valid;
  rdb_pkg::res_kind_t   iss_kind;
  logic                 iss_last;

  // result queue
  rdb_pkg::result_t              oq [rdb_pkg::OQ_DEPTH];
  logic [OQ_PW-1:0]              oq_wr;
  logic [OQ_PW-1:0]              oq_rd;
  logic [rdb_pkg::OQ_CNT_W-1:0]  oq_count;
  rdb_pkg::result_t              oq_in;
  logic                          oq_pop;

  logic               credit_ok;
  logic               exec;
  logic               start_run;
  logic               issue_valid;
  rdb_pkg::res_kind_t issue_kind;
  logic               issue_last;
  logic               rd_en;
  logic               run_last;
  logic               do_append;

  assign credit_ok = (oq_count + rdb_pkg::OQ_CNT_W'(iss_valid)) <= OQ_CREDIT;
  assign run_last  = (rd_ptr == rd_end);
  assign do_append = exec && (cmd.op == rdb_pkg::OP_APPEND) && (tail < DEPTH_IDX);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rdb_pkg::BK_IDLE: if (start_run) state_next = rdb_pkg::BK_RUN;
      rdb_pkg::BK_RUN:  if (credit_ok && run_last) state_next = rdb_pkg::BK_IDLE;
      default:          state_next = rdb_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_ready   = (state == rdb_pkg::BK_IDLE) && credit_ok;
    exec        = cmd_valid && cmd_ready;
    start_run   = 1'b0;
    issue_valid = 1'b0;
    issue_kind  = rdb_pkg::RK_DATA;
    issue_last  = 1'b1;
    rd_en       = 1'b0;
    case (state)
      rdb_pkg::BK_IDLE: begin
        if (exec && cmd.op == rdb_pkg::OP_EMIT) begin
          if (failed || loaded != declared) begin
            issue_valid = 1'b1;
            issue_kind  = rdb_pkg::RK_ERROR;
          end else if (head >= tail) begin
            issue_valid = 1'b1;
            issue_kind  = rdb_pkg::RK_EMPTY;
          end else begin
            start_run = 1'b1;
          end
        end
      end
      rdb_pkg::BK_RUN: begin
        if (credit_ok) begin
          issue_valid = 1'b1;
          issue_last  = run_last;
          rd_en       = 1'b1;
        end
      end
      default: begin
        issue_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdb_pkg::BK_IDLE;
      head      <= '0;
      tail      <= '0;
      loaded    <= '0;
      declared  <= '0;
      reversed  <= 1'b0;
      failed    <= 1'b0;
      iss_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iss_valid <= issue_valid;
      if (exec) begin
        case (cmd.op)
          rdb_pkg::OP_CLEAR: begin
            head     <= '0;
            tail     <= '0;
            loaded   <= '0;
            declared <= cmd.expected_count;
            reversed <= 1'b0;
            failed   <= 1'b0;
          end
          rdb_pkg::OP_APPEND: begin
            if (tail >= DEPTH_IDX) begin
              failed <= 1'b1;
            end else begin
              tail   <= tail + 1'b1;
              loaded <= loaded + 1'b1;
            end
          end
          rdb_pkg::OP_REVERSE: reversed <= !reversed;
          rdb_pkg::OP_DELETE: begin
            if (head >= tail) begin
              failed <= 1'b1;
            end else if (reversed) begin
              tail <= tail - 1'b1;
            end else begin
              head <= head + 1'b1;
            end
          end
          rdb_pkg::OP_EMIT: failed <= failed;
          default:          failed <= 1'b1;
        endcase
      end
    end
  end

  // run pointers and issue payload
  always_ff @(posedge clk) begin
    if (start_run) begin
      rd_ptr  <= reversed ? tail - 1'b1 : head;
      rd_end  <= reversed ? head : tail - 1'b1;
      rd_down <= reversed;
    end else if (rd_en && !run_last) begin
      rd_ptr <= rd_down ? rd_ptr - 1'b1 : rd_ptr + 1'b1;
    end
    if (issue_valid) begin
      iss_kind <= issue_kind;
      iss_last <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      mem[tail[AW-1:0]] <= cmd.value[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_ptr[AW-1:0]];
    end
  end

  // result queue
  always_comb begin
    oq_in.value_res = (iss_kind == rdb_pkg::RK_DATA) ? rdb_pkg::DATA_BITS'(mem_q) : '0;
    oq_in.is_error  = (iss_kind == rdb_pkg::RK_ERROR);
    oq_in.is_empty  = (iss_kind == rdb_pkg::RK_EMPTY);
    oq_in.last      = iss_last;
  end

  assign result_valid = (oq_count != '0);
  assign result       = oq[oq_rd];
  assign oq_pop       = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (iss_valid) oq_wr <= oq_wr + 1'b1;
      if (oq_pop)    oq_rd <= oq_rd + 1'b1;
      if (iss_valid && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !iss_valid) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_valid) begin
      oq[oq_wr] <= oq_in;
    end
  end

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("head index passed tail index");
  a_tail_bound: assert property (@(posedge clk) disable iff (rst) tail <= DEPTH_IDX)
    else $error("tail index beyond buffer depth");
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    iss_valid |-> oq_count < OQ_FULL)
    else $error("result queue overflow");
  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    state == rdb_pkg::BK_RUN |-> (rd_ptr >= head && rd_ptr < tail))
    else $error("emit read outside the live list");

endmodule
